### hdl/ets_pkg.sv
// Package for the expression token scanner: result and queue entry types,
// character constants and byte classification functions.
// No dependencies; ets_front, ets_queue, ets_back and the core import it.
package ets_pkg;

  localparam int PosBits    = 16;
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharUnder = 8'h5f;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharStar  = 8'h2a;
  localparam logic [7:0] CharSlash = 8'h2f;
  localparam logic [7:0] CharLpar  = 8'h28;
  localparam logic [7:0] CharRpar  = 8'h29;
  localparam logic [7:0] CharEqual = 8'h3d;

  typedef enum logic [3:0] {
    KindNumber  = 4'd0,
    KindIdent   = 4'd1,
    KindPlus    = 4'd2,
    KindMinus   = 4'd3,
    KindMul     = 4'd4,
    KindDiv     = 4'd5,
    KindLparen  = 4'd6,
    KindRparen  = 4'd7,
    KindEquals  = 4'd8,
    KindUnknown = 4'd9,
    KindEnd     = 4'd10
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [7:0]  bad;
    logic        ovf;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == CharPlus) || (c == CharMinus) || (c == CharStar) ||
           (c == CharSlash) || (c == CharLpar) || (c == CharRpar) ||
           (c == CharEqual);
  endfunction

  function automatic kind_e op_kind(input logic [7:0] c);
    kind_e k;
    k = KindUnknown;
    if (c == CharPlus) k = KindPlus;
    if (c == CharMinus) k = KindMinus;
    if (c == CharStar) k = KindMul;
    if (c == CharSlash) k = KindDiv;
    if (c == CharLpar) k = KindLparen;
    if (c == CharRpar) k = KindRparen;
    if (c == CharEqual) k = KindEquals;
    return k;
  endfunction

  function automatic logic [15:0] sat16(input logic [PosBits-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_ffff) ? 16'hffff : w[15:0];
  endfunction

endpackage

### hdl/ets_in_if.sv
// Input channel of the token scanner: one text byte per transaction.
// Depends on nothing.
interface ets_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

### hdl/ets_out_if.sv
// Output channel of the token scanner: one token result per transaction.
// Depends on nothing.
interface ets_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [7:0]  offending_byte;
  logic        position_overflow;
  logic        run_last;

  modport source (output valid, token_kind, token_start, token_length,
                  offending_byte, position_overflow, run_last, input ready);
  modport sink (input valid, token_kind, token_start, token_length,
                offending_byte, position_overflow, run_last, output ready);
endinterface

### hdl/ets_front.sv
// Front end of the token scanner: takes text bytes, holds the scan state
// and builds up to two results per byte. Depends on ets_pkg and ets_in_if.
module ets_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  ets_in_if.sink          in_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output ets_pkg::entry_t push_entry_o
);
  import ets_pkg::*;

  typedef enum logic [2:0] {
    ModeIdle,
    ModeInt,
    ModeFrac,
    ModeIdent,
    ModeOwed,
    ModeDone
  } mode_e;

  mode_e              mode_q, mode_d;
  logic [PosBits-1:0] begin_q, begin_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic               ovf_q, ovf_d;
  result_t            res [2];
  logic [1:0]         n;
  logic               accept;

  function automatic logic in_tok(input mode_e m);
    return (m == ModeInt) || (m == ModeFrac) || (m == ModeIdent);
  endfunction

  function automatic kind_e pend_kind(input mode_e m);
    return (m == ModeIdent) ? KindIdent : KindNumber;
  endfunction

  function automatic result_t make_res(input kind_e k, input logic [PosBits-1:0] s,
                                       input logic [PosBits-1:0] len,
                                       input logic [7:0] b, input logic o);
    result_t r;
    r.kind   = k;
    r.start  = sat16(s);
    r.length = sat16(len);
    r.bad    = b;
    r.ovf    = o;
    r.last   = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic       ext;
    c       = in_i.text_byte;
    mode_d  = mode_q;
    begin_d = begin_q;
    pos_d   = pos_q;
    ovf_d   = ovf_q;
    res[0]  = '0;
    res[1]  = '0;
    n       = 2'd0;
    ext     = 1'b0;
    unique case (mode_q)
      ModeDone: begin
      end
      ModeOwed: begin
        res[0] = make_res(KindEnd, pos_q, '0, 8'h00, ovf_q);
        n      = 2'd1;
        mode_d = ModeDone;
      end
      default: begin
        if (c == CharNul) begin
          if (in_tok(mode_q)) begin
            res[n[0]] = make_res(pend_kind(mode_q), begin_q, pos_q - begin_q, 8'h00, ovf_q);
            n = n + 2'd1;
          end
          res[n[0]] = make_res(KindEnd, pos_q, '0, 8'h00, ovf_q);
          n = n + 2'd1;
          mode_d = ModeDone;
        end else begin
          if (pos_q != PosMax) begin
            pos_d = pos_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          ext = ((mode_q == ModeInt) && (is_digit(c) || (c == CharDot))) ||
                ((mode_q == ModeFrac) && is_digit(c)) ||
                ((mode_q == ModeIdent) && (is_alpha(c) || is_digit(c) || (c == CharUnder)));
          if (ext) begin
            if ((mode_q == ModeInt) && (c == CharDot)) begin
              mode_d = ModeFrac;
            end
          end else begin
            if (in_tok(mode_q)) begin
              res[n[0]] = make_res(pend_kind(mode_q), begin_q, pos_q - begin_q, 8'h00, ovf_d);
              n = n + 2'd1;
              mode_d = ModeIdle;
            end
            priority if (is_space(c)) begin
            end else if (is_digit(c)) begin
              mode_d  = ModeInt;
              begin_d = pos_q;
            end else if (is_alpha(c) || (c == CharUnder)) begin
              mode_d  = ModeIdent;
              begin_d = pos_q;
            end else if (is_op(c)) begin
              res[n[0]] = make_res(op_kind(c), pos_q, PosBits'(1), 8'h00, ovf_d);
              n = n + 2'd1;
            end else begin
              res[n[0]] = make_res(KindUnknown, pos_q, PosBits'(1), c, ovf_d);
              n = n + 2'd1;
            end
          end
          if (in_i.end_of_text) begin
            if (in_tok(mode_d)) begin
              res[n[0]] = make_res(pend_kind(mode_d), begin_d, pos_d - begin_d, 8'h00, ovf_d);
              n = n + 2'd1;
              mode_d = ModeIdle;
            end
            if (n < 2'd2) begin
              res[n[0]] = make_res(KindEnd, pos_d, '0, 8'h00, ovf_d);
              n = n + 2'd1;
              mode_d = ModeDone;
            end else begin
              mode_d = ModeOwed;
            end
          end
        end
      end
    endcase
    if (n == 2'd2) begin
      res[1].last = 1'b1;
    end else if (n == 2'd1) begin
      res[0].last = 1'b1;
    end
  end

  assign accept              = in_i.valid && push_ready_i;
  assign in_i.ready          = push_ready_i;
  assign push_valid_o        = accept && (n != 2'd0);
  assign push_entry_o.two    = (n == 2'd2);
  assign push_entry_o.first  = res[0];
  assign push_entry_o.second = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      begin_q <= '0;
      pos_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      begin_q <= begin_d;
      pos_q   <= pos_d;
      ovf_q   <= ovf_d;
    end
  end
endmodule

### hdl/ets_queue.sv
// Short queue of result entries between the front and back ends.
// Depends on ets_pkg.
module ets_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  ets_pkg::entry_t push_entry_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output ets_pkg::entry_t pop_entry_o
);
  import ets_pkg::*;

  entry_t             mem_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueAw:0]   count_q;
  logic               do_push, do_pop;

  assign push_ready_o = (count_q != (QueueAw + 1)'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!do_push && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end
endmodule

### hdl/ets_back.sv
// Back end of the token scanner: drains queue entries one result at a time
// into the output register. Depends on ets_pkg and ets_out_if.
module ets_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  ets_pkg::entry_t head_entry_i,
  output logic            pop_o,
  ets_out_if.source       out_o
);
  import ets_pkg::*;

  logic    valid_q, valid_d;
  logic    sel_q, sel_d;
  result_t res_q, res_d;
  logic    load;

  assign load = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    res_d   = res_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        res_d = sel_q ? head_entry_i.second : head_entry_i.first;
        if (head_entry_i.two && !sel_q) begin
          sel_d = 1'b1;
        end else begin
          sel_d = 1'b0;
          pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid             = valid_q;
  assign out_o.token_kind        = res_q.kind;
  assign out_o.token_start       = res_q.start;
  assign out_o.token_length      = res_q.length;
  assign out_o.offending_byte    = res_q.bad;
  assign out_o.position_overflow = res_q.ovf;
  assign out_o.run_last          = res_q.last;
endmodule

### hdl/expression_token_scanner_core.sv
// Expression token scanner: splits a byte stream into number, identifier,
// operator, unknown and end tokens. Uses ets_pkg, both channel interfaces,
// ets_front, ets_queue and ets_back.
//
// The input channel carries one text byte per transaction, with a flag on
// the last byte of the text; a zero byte also ends the text. The output
// channel carries one token result per transaction, and run_last marks the
// last result that a given byte produced.
// A byte is taken in every cycle while the four-entry result queue has room.
// Each byte gives zero, one or two results; the output register sends one
// result per cycle while the receiver is ready, so a byte with two results
// keeps its queue entry until both are sent. Results go through the queue
// and the output register. When the receiver stalls, results collect in
// the queue and the input keeps flowing until it is full, then ready drops.
// Reset clears the scan state, the position and the overflow flag and
// empties the queue. After the end token the block drops every byte until
// the next reset.
module expression_token_scanner_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  ets_in_if.sink     in_i,
  ets_out_if.source  out_o
);
  import ets_pkg::*;

  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   head_valid, pop;
  entry_t head_entry;

  ets_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_entry_o(push_entry)
  );

  ets_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_entry_i(push_entry),
    .pop_valid_o (head_valid),
    .pop_ready_i (pop),
    .pop_entry_o (head_entry)
  );

  ets_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_entry_i(head_entry),
    .pop_o       (pop),
    .out_o       (out_o)
  );

  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid && !push_entry.two |-> push_entry.first.last)
    else $error("single result entry not marked last");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid && push_entry.two |-> push_entry.second.last && !push_entry.first.last)
    else $error("two result entry has wrong last marks");

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_end_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.token_kind == KindEnd) |->
      out_o.run_last && (out_o.token_length == 16'h0000))
    else $error("end token malformed");
endmodule
